// File: src/sync_framed_packet_crc_checker_core_macros.svh
`ifndef SYNC_FRAMED_PACKET_CRC_CHECKER_CORE_MACROS_SVH
`define SYNC_FRAMED_PACKET_CRC_CHECKER_CORE_MACROS_SVH

// concurrent check, quiet while reset is asserted
`define SFPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check that also holds during reset
`define SFPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sfpc_pkg.sv
package sfpc_pkg;

  localparam int SYNC_BYTES = 3;
  localparam int SYNC_W     = 24;
  localparam logic [SYNC_W-1:0] SYNC_MASK =
    SYNC_W'((33'(1) << (8 * SYNC_BYTES)) - 33'(1));

  localparam logic [23:0] SYNC_WORD_RST   = 24'h4C4135;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  localparam logic REG_SYNC_WORD   = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    OP_SYNC    = 3'd0,
    OP_HDR     = 3'd1,
    OP_REJECT  = 3'd2,
    OP_PAYLOAD = 3'd3,
    OP_CRC_LO  = 3'd4,
    OP_CRC_HI  = 3'd5
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic [SYNC_W-1:0] sync;
    logic [15:0]       frame_type;
    logic [15:0]       frame_length;
  } q_entry_t;

  // crc-16/ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

  function automatic logic [15:0] sync_crc(input logic [SYNC_W-1:0] s);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int k = SYNC_BYTES - 1; k >= 0; k--) begin
      crc = crc_step(crc, s[8*k +: 8]);
    end
    return crc;
  endfunction

endpackage

// File: src/sfpc_front.sv
module sfpc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic [23:0]                sync_word_i,
  input  logic [15:0]                max_payload_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output sfpc_pkg::q_entry_t         q_entry_o
);
  import sfpc_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CRC_LO  = 5'b01000,
    PH_CRC_HI  = 5'b10000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [SYNC_W-1:0] shift_q, shift_d;
  logic [15:0]       cnt_q, cnt_d;
  logic [15:0]       type_q, type_d;
  logic [15:0]       len_q, len_d;
  logic              accept;
  logic [SYNC_W-1:0] shift_n;
  logic [15:0]       cnt_sat;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign shift_n    = {shift_q[SYNC_W-9:0], data_byte_i};
  assign cnt_sat    = (cnt_q < 16'(SYNC_BYTES)) ? cnt_q + 16'd1 : cnt_q;

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    type_d  = type_q;
    len_d   = len_q;
    q_push_o = 1'b0;
    q_entry_o.op   = OP_HDR;
    q_entry_o.data = data_byte_i;
    q_entry_o.sync = shift_n;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          shift_d = shift_n;
          cnt_d   = cnt_sat;
          if (cnt_sat >= 16'(SYNC_BYTES) &&
              (shift_n & SYNC_MASK) == (sync_word_i & SYNC_MASK)) begin
            q_push_o     = 1'b1;
            q_entry_o.op = OP_SYNC;
            phase_d      = PH_HEADER;
            cnt_d        = '0;
          end
        end
        PH_HEADER: begin
          q_push_o = 1'b1;
          unique case (cnt_q[2:0])
            3'd0:    type_d = {8'h00, data_byte_i};
            3'd1:    type_d = {data_byte_i, type_q[7:0]};
            3'd4:    len_d  = {8'h00, data_byte_i};
            3'd5:    len_d  = {data_byte_i, len_q[7:0]};
            default: ;
          endcase
          if (cnt_q < 16'd5) begin
            cnt_d = cnt_q + 16'd1;
          end else if (len_d > max_payload_i) begin
            q_entry_o.op = OP_REJECT;
            phase_d      = PH_HUNT;
            shift_d      = '0;
            cnt_d        = '0;
          end else if (len_d == 16'd0) begin
            phase_d = PH_CRC_LO;
            cnt_d   = '0;
          end else begin
            phase_d = PH_PAYLOAD;
            cnt_d   = len_d;
          end
        end
        PH_PAYLOAD: begin
          q_push_o     = 1'b1;
          q_entry_o.op = OP_PAYLOAD;
          cnt_d        = cnt_q - 16'd1;
          if (cnt_d == 16'd0) phase_d = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          q_push_o     = 1'b1;
          q_entry_o.op = OP_CRC_LO;
          phase_d      = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          q_push_o     = 1'b1;
          q_entry_o.op = OP_CRC_HI;
          phase_d      = PH_HUNT;
          shift_d      = '0;
          cnt_d        = '0;
        end
        default: begin
          phase_d = PH_HUNT;
          shift_d = '0;
          cnt_d   = '0;
        end
      endcase
    end
    q_entry_o.frame_type   = type_d;
    q_entry_o.frame_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      shift_q <= '0;
      cnt_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      len_q   <= len_d;
    end
  end

endmodule

// File: src/sfpc_queue.sv
module sfpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfpc_pkg::q_entry_t entry_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output sfpc_pkg::q_entry_t entry_o
);
  import sfpc_pkg::*;

  q_entry_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ptr_inc(wr_q);
      if (do_pop)  rd_q <= ptr_inc(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

// File: src/sfpc_back.sv
`include "sync_framed_packet_crc_checker_core_macros.svh"

module sfpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  sfpc_pkg::q_entry_t q_entry_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [7:0]         payload_byte_o,
  output logic [15:0]        frame_type_o,
  output logic [15:0]        frame_length_o,
  output logic [1:0]         status_o,
  output logic               last_of_frame_o
);
  import sfpc_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        ov_q, ov_d;
  logic        kind_q, kind_d;
  logic [7:0]  pb_q, pb_d;
  logic [15:0] type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [1:0]  st_q, st_d;
  logic        last_q, last_d;
  logic        go, emit;
  logic [15:0] crc_upd;

  // pop whenever the output register is free or being drained
  assign go      = q_valid_i && (!ov_q || !out_stall_i);
  assign q_pop_o = go;
  assign crc_upd = crc_step(crc_q, q_entry_i.data);

  always_comb begin
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    emit     = 1'b0;
    kind_d   = KIND_SUMMARY;
    pb_d     = 8'h00;
    st_d     = ST_OK;
    last_d   = 1'b1;
    type_d   = q_entry_i.frame_type;
    len_d    = q_entry_i.frame_length;
    if (go) begin
      unique case (q_entry_i.op)
        OP_SYNC: crc_d = sync_crc(q_entry_i.sync);
        OP_HDR:  crc_d = crc_upd;
        OP_REJECT: begin
          emit = 1'b1;
          st_d = ST_TOO_LONG;
        end
        OP_PAYLOAD: begin
          crc_d  = crc_upd;
          emit   = 1'b1;
          kind_d = KIND_PAYLOAD;
          pb_d   = q_entry_i.data;
          last_d = 1'b0;
        end
        OP_CRC_LO: crc_lo_d = q_entry_i.data;
        OP_CRC_HI: begin
          emit = 1'b1;
          st_d = ({q_entry_i.data, crc_lo_q} == crc_q) ? ST_OK : ST_MISMATCH;
        end
        default: ;
      endcase
    end
    ov_d = go ? emit : (ov_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      crc_q    <= CRC_INIT;
      crc_lo_q <= '0;
    end else begin
      ov_q     <= ov_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      kind_q <= kind_d;
      pb_q   <= pb_d;
      type_q <= type_d;
      len_q  <= len_d;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = pb_q;
  assign frame_type_o    = type_q;
  assign frame_length_o  = len_q;
  assign status_o        = st_q;
  assign last_of_frame_o = last_q;

  `SFPC_ASSERT(a_crc_hi_summary, clk_i, rst_ni,
    (go && q_entry_i.op == OP_CRC_HI) |=> (ov_q && kind_q == KIND_SUMMARY && last_q),
    "closing crc byte did not produce a summary")
  `SFPC_ASSERT(a_crc_lo_silent, clk_i, rst_ni,
    (go && q_entry_i.op == OP_CRC_LO) |=> !ov_q,
    "low crc byte produced a result")
  `SFPC_ASSERT(a_too_long_summary, clk_i, rst_ni,
    (ov_q && st_q == ST_TOO_LONG) |-> (kind_q == KIND_SUMMARY && last_q && pb_q == 8'h00),
    "length reject not flagged as a frame summary")
  `SFPC_ASSERT_ALWAYS(a_reset_idle, clk_i,
    !rst_ni |=> !ov_q,
    "result shown during reset")

endmodule

// File: src/sync_framed_packet_crc_checker_core.sv
// Framed packet parser with CRC-16/CCITT-FALSE check. One received byte per item; the block
// sustains one item per clock while out_stall_i is low, set by the per-byte phase logic in
// the front parser and the single CRC byte step in the back stage, with a two-entry queue
// between them. The byte that causes a result is written into the queue, and the result is
// then registered in the output register. Sync-hunt bytes (the one completing a match too),
// header bytes, and the low CRC byte cause no result. Each payload byte gives a kind 0
// result, and the high CRC byte (or the last header byte when the length exceeds
// max_payload) gives a kind 1 summary with status 0 ok, 1 mismatch or 2 too long. Registers:
// sync_word at address 0, max_payload at address 4; write them only while the block is idle.
module sync_framed_packet_crc_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] frame_type_o,
  output logic [15:0] frame_length_o,
  output logic [1:0]  status_o,
  output logic        last_of_frame_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfpc_pkg::*;

  logic [23:0] sync_word_q;
  logic [15:0] max_payload_q;
  logic        cfg_wr;
  logic        q_full, q_push, q_valid, q_pop;
  q_entry_t    q_in, q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {16'h0000, max_payload_q}
                                                : {8'h00, sync_word_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q   <= SYNC_WORD_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SYNC_WORD:   sync_word_q   <= pwdata[23:0];
        REG_MAX_PAYLOAD: max_payload_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  sfpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .sync_word_i   (sync_word_q),
    .max_payload_i (max_payload_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  sfpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_out)
  );

  sfpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_entry_i       (q_out),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_type_o    (frame_type_o),
    .frame_length_o  (frame_length_o),
    .status_o        (status_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
